[hw/rtl/gdda_pkg.sv]
package gdda_pkg;

    localparam int MAP_DIM_DEF = 32;
    localparam int MAX_SCREEN  = 1024;

    localparam int DIV_W  = 29;
    localparam int DIST_W = 40;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [2:0] REG_POS_X  = 3'd0;
    localparam logic [2:0] REG_POS_Y  = 3'd1;
    localparam logic [2:0] REG_DIR_X  = 3'd2;
    localparam logic [2:0] REG_DIR_Y  = 3'd3;
    localparam logic [2:0] REG_PLN_X  = 3'd4;
    localparam logic [2:0] REG_PLN_Y  = 3'd5;
    localparam logic [2:0] REG_COLS   = 3'd6;
    localparam logic [2:0] REG_ROWS   = 3'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

endpackage

[hw/rtl/gdda_div.sv]
module gdda_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [gdda_pkg::DIV_W-1:0]       i_dividend,
    input  logic [gdda_pkg::DIST_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [gdda_pkg::DIV_W-1:0]       o_quot
);
    localparam int CW = $clog2(gdda_pkg::DIV_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [gdda_pkg::DIV_W-1:0]    r_q;
    logic [gdda_pkg::DIST_W-1:0]   r_rem;
    logic [gdda_pkg::DIST_W-1:0]   r_dvs;
    logic [gdda_pkg::DIST_W:0]     shifted;
    logic [gdda_pkg::DIST_W:0]     diff;
    logic                          ge;
    logic [gdda_pkg::DIST_W-1:0]   n_rem;

    always_comb begin
        shifted = {r_rem, r_q[gdda_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = shifted >= {1'b0, r_dvs};
        n_rem   = ge ? diff[gdda_pkg::DIST_W-1:0] : shifted[gdda_pkg::DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(gdda_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[gdda_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[hw/rtl/grid_dda_ray_column_caster.sv]
// Cell write: no result.
// Cast: setup, then up to three bit-serial divisions (column, 1/|ray x|,
// 1/|ray y|), then grid steps (step, cell read, test) for up to 2*MAP_DIM+2 steps,
// and one more division for the span if a wall is found.
// One cast at a time; a finished result waits in the output register while stalled.
// Reset: synchronous, active low; then a clearing pass over all MAP_DIM*MAP_DIM cells.
module grid_dda_ray_column_caster #(
    parameter int MAP_DIM = gdda_pkg::MAP_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [4:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    input  logic [7:0]  i_cell_value,
    input  logic [9:0]  i_column,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_out_column,
    output logic [9:0]  o_span_top,
    output logic [9:0]  o_span_bottom,
    output logic        o_hit_side,
    output logic        o_wall_found,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int DEPTH = MAP_DIM * MAP_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIMIT = 2 * MAP_DIM + 2;
    localparam int NW    = $clog2(LIMIT + 1);
    localparam int DW    = gdda_pkg::DIST_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CAM  = 4'd2;
    localparam logic [3:0] S_MX   = 4'd3;
    localparam logic [3:0] S_MY   = 4'd4;
    localparam logic [3:0] S_RY   = 4'd5;
    localparam logic [3:0] S_DX0  = 4'd6;
    localparam logic [3:0] S_DXW  = 4'd7;
    localparam logic [3:0] S_DY0  = 4'd8;
    localparam logic [3:0] S_DYW  = 4'd9;
    localparam logic [3:0] S_SX   = 4'd10;
    localparam logic [3:0] S_SY   = 4'd11;
    localparam logic [3:0] S_ST0  = 4'd12;
    localparam logic [3:0] S_STEP = 4'd13;
    localparam logic [3:0] S_LOOK = 4'd14;
    localparam logic [3:0] S_DIST = 4'd15;

    // extra phases share the sequencer via secondary flags
    logic [3:0]  r_state;
    logic        r_chk;
    logic        r_dlw;
    logic        r_fin;

    logic [15:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_pln_x, r_pln_y;
    logic [10:0]        r_cols, r_rows;

    logic [7:0]         mem [DEPTH];
    logic [7:0]         r_rd;
    logic [AW-1:0]      r_clr;

    logic [9:0]         r_col;
    logic signed [24:0] r_cam;
    logic signed [31:0] r_rx, r_ry;
    logic [DW-1:0]      r_dx, r_dy, r_sx, r_sy;
    logic signed [9:0]  r_mx, r_my;
    logic [NW-1:0]      r_n;
    logic               r_side, r_found;
    logic [10:0]        r_top, r_bot;
    logic signed [45:0] r_prod;

    logic               r_ovalid;
    logic [9:0]         r_ocol, r_otop, r_obot;
    logic               r_oside, r_ofound;

    logic [10:0]        w, h, hh;
    logic signed [15:0] mul_a;
    logic signed [29:0] mul_b;
    logic               div_start, div_done;
    logic [gdda_pkg::DIV_W-1:0]  div_dvd, div_q;
    logic [DW-1:0]      div_dvs;
    logic [31:0]        abs_rx, abs_ry;
    logic [11:0]        fx, fy;
    logic [DW-1:0]      init_side;
    logic [DW-1:0]      perp;
    logic [DW:0]        sum_x, sum_y;
    logic [31:0]        rd_addr, wr_addr;
    logic               out_of_map, in_acc, out_free;
    logic [27:0]        half;
    logic [28:0]        bsum;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_chk || r_dlw || r_fin;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w = (r_cols == 11'd0) ? 11'd1 :
            (32'(r_cols) > gdda_pkg::MAX_SCREEN) ? 11'(gdda_pkg::MAX_SCREEN) : r_cols;
        h = (r_rows == 11'd0) ? 11'd1 :
            (32'(r_rows) > gdda_pkg::MAX_SCREEN) ? 11'(gdda_pkg::MAX_SCREEN) : r_rows;
        hh = {1'b0, h[10:1]};
        abs_rx = r_rx[31] ? 32'(-r_rx) : 32'(r_rx);
        abs_ry = r_ry[31] ? 32'(-r_ry) : 32'(r_ry);
        fx = r_rx[31] ? {1'b0, r_pos_x[10:0]} : 12'd2048 - {1'b0, r_pos_x[10:0]};
        fy = r_ry[31] ? {1'b0, r_pos_y[10:0]} : 12'd2048 - {1'b0, r_pos_y[10:0]};
        sum_x = {1'b0, r_sx} + {1'b0, r_dx};
        sum_y = {1'b0, r_sy} + {1'b0, r_dy};
        perp = r_side ? r_sy - r_dy : r_sx - r_dx;
        rd_addr = 32'(r_mx[8:0]) * 32'(MAP_DIM) + 32'(r_my[8:0]);
        wr_addr = 32'(i_cell_x) * 32'(MAP_DIM) + 32'(i_cell_y);
        out_of_map = r_mx[9] || r_my[9] || (r_mx >= 10'(MAP_DIM)) || (r_my >= 10'(MAP_DIM));
        half = div_q[28:1];
        bsum = 29'(half) + 29'(hh);
    end

    // shared multiplier operands
    always_comb begin
        mul_a = r_pln_x;
        mul_b = 30'(r_cam);
        case (r_state)
            S_MY:    begin mul_a = r_pln_y; mul_b = 30'(r_cam); end
            S_SX:    begin mul_a = $signed({4'b0, fx}); mul_b = $signed({1'b0, r_dx[28:0]}); end
            S_SY:    begin mul_a = $signed({4'b0, fy}); mul_b = $signed({1'b0, r_dy[28:0]}); end
            default: begin mul_a = r_pln_x; mul_b = 30'(r_cam); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // side distance from the product of the previous state
    always_comb begin
        logic [11:0] f;
        logic        dmax;
        f    = (r_state == S_SY) ? fx : fy;
        dmax = (r_state == S_SY) ? (r_dx == gdda_pkg::DIST_MAX) : (r_dy == gdda_pkg::DIST_MAX);
        if (dmax) begin
            if (f == 12'd0)         init_side = '0;
            else if (f == 12'd2048) init_side = gdda_pkg::DIST_MAX;
            else                    init_side = {f[10:0], 29'd0} - 40'd1;
        end else begin
            init_side = 40'(r_prod[45:11]);
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = 40'(w);
        if (in_acc && i_action == gdda_pkg::ACT_CAST) begin
            div_start = 1'b1;
            div_dvd   = {6'd0, i_column, 13'd0};
            div_dvs   = 40'(w);
        end else if (r_state == S_DX0 && !r_chk && r_rx != 32'sd0) begin
            div_start = 1'b1;
            div_dvd   = 29'h1000_0000;
            div_dvs   = 40'(abs_rx);
        end else if (r_state == S_DY0 && r_ry != 32'sd0) begin
            div_start = 1'b1;
            div_dvd   = 29'h1000_0000;
            div_dvs   = 40'(abs_ry);
        end else if (r_state == S_DIST && !r_dlw && perp != '0) begin
            div_start = 1'b1;
            div_dvd   = {h, 16'd0, 2'd0} >> 2;
            div_dvs   = perp;
        end
    end

    gdda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            mem[r_clr] <= 8'd0;
        end else if (in_acc && i_action == gdda_pkg::ACT_WRITE &&
                     32'(i_cell_x) < 32'(MAP_DIM) && 32'(i_cell_y) < 32'(MAP_DIM)) begin
            mem[wr_addr[AW-1:0]] <= i_cell_value;
        end
        r_rd <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_dir_x <= 16'sd4096;
            r_dir_y <= '0;
            r_pln_x <= '0;
            r_pln_y <= 16'sd2703;
            r_cols  <= 11'd640;
            r_rows  <= 11'd480;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gdda_pkg::REG_POS_X: r_pos_x <= i_cfg_data;
                gdda_pkg::REG_POS_Y: r_pos_y <= i_cfg_data;
                gdda_pkg::REG_DIR_X: r_dir_x <= i_cfg_data;
                gdda_pkg::REG_DIR_Y: r_dir_y <= i_cfg_data;
                gdda_pkg::REG_PLN_X: r_pln_x <= i_cfg_data;
                gdda_pkg::REG_PLN_Y: r_pln_y <= i_cfg_data;
                gdda_pkg::REG_COLS:  r_cols  <= i_cfg_data[10:0];
                gdda_pkg::REG_ROWS:  r_rows  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_chk    <= 1'b0;
            r_dlw    <= 1'b0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_fin && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_fin) begin
                if (out_free) begin
                    r_ocol   <= r_col;
                    r_otop   <= r_top[9:0];
                    r_obot   <= r_bot[9:0];
                    r_oside  <= r_side;
                    r_ofound <= r_found;
                    r_fin    <= 1'b0;
                    r_state  <= S_IDLE;
                end
            end else if (r_chk) begin
                // cell read issued this cycle
                r_chk <= 1'b0;
                if (out_of_map) begin
                    r_top <= '0; r_bot <= '0; r_fin <= 1'b1;
                end else begin
                    r_state <= S_LOOK;
                end
            end else if (r_dlw) begin
                if (div_done) begin
                    r_dlw <= 1'b0;
                    r_top <= (half > 28'(hh)) ? 11'd0 : hh - half[10:0];
                    r_bot <= (bsum >= 29'(h)) ? h - 11'd1 : bsum[10:0];
                    r_fin <= 1'b1;
                end
            end else begin
                case (r_state)
                    S_CLR: begin
                        r_clr <= r_clr + 1'b1;
                        if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (in_acc && i_action == gdda_pkg::ACT_CAST) begin
                            r_col   <= i_column;
                            r_state <= S_CAM;
                        end
                    end
                    S_CAM: begin
                        if (div_done) begin
                            r_cam   <= $signed({1'b0, div_q[23:0]}) - 25'sd4096;
                            r_state <= S_MX;
                        end
                    end
                    S_MX: r_state <= S_MY;
                    S_MY: begin
                        r_rx    <= 32'(46'(r_dir_x) + (r_prod >>> 12));
                        r_state <= S_RY;
                    end
                    S_RY: begin
                        r_ry    <= 32'(46'(r_dir_y) + (r_prod >>> 12));
                        r_state <= S_DX0;
                    end
                    S_DX0: begin
                        if (r_rx == 32'sd0) begin
                            r_dx    <= gdda_pkg::DIST_MAX;
                            r_state <= S_DY0;
                        end else begin
                            r_state <= S_DXW;
                        end
                    end
                    S_DXW: begin
                        if (div_done) begin
                            r_dx    <= 40'(div_q);
                            r_state <= S_DY0;
                        end
                    end
                    S_DY0: begin
                        if (r_ry == 32'sd0) begin
                            r_dy    <= gdda_pkg::DIST_MAX;
                            r_state <= S_SX;
                        end else begin
                            r_state <= S_DYW;
                        end
                    end
                    S_DYW: begin
                        if (div_done) begin
                            r_dy    <= 40'(div_q);
                            r_state <= S_SX;
                        end
                    end
                    S_SX: r_state <= S_SY;
                    S_SY: begin
                        r_sx    <= init_side;
                        r_state <= S_ST0;
                    end
                    S_ST0: begin
                        r_sy    <= init_side;
                        r_mx    <= $signed({5'd0, r_pos_x[15:11]});
                        r_my    <= $signed({5'd0, r_pos_y[15:11]});
                        r_n     <= '0;
                        r_side  <= 1'b0;
                        r_found <= 1'b0;
                        if (32'(r_pos_x[15:11]) < 32'(MAP_DIM) &&
                            32'(r_pos_y[15:11]) < 32'(MAP_DIM)) begin
                            r_state <= S_STEP;
                        end else begin
                            r_top <= '0; r_bot <= '0; r_fin <= 1'b1;
                        end
                    end
                    S_STEP: begin
                        if (r_sx < r_sy) begin
                            r_sx   <= sum_x[DW] ? gdda_pkg::DIST_MAX : sum_x[DW-1:0];
                            r_mx   <= r_rx[31] ? r_mx - 10'sd1 : r_mx + 10'sd1;
                            r_side <= 1'b0;
                        end else begin
                            r_sy   <= sum_y[DW] ? gdda_pkg::DIST_MAX : sum_y[DW-1:0];
                            r_my   <= r_ry[31] ? r_my - 10'sd1 : r_my + 10'sd1;
                            r_side <= 1'b1;
                        end
                        r_n   <= r_n + 1'b1;
                        r_chk <= 1'b1;
                    end
                    S_LOOK: begin
                        if (r_rd != 8'd0) begin
                            r_found <= 1'b1;
                            r_state <= S_DIST;
                        end else if (r_n == NW'(LIMIT)) begin
                            r_top <= '0; r_bot <= '0; r_fin <= 1'b1;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end
                    S_DIST: begin
                        if (perp == '0) begin
                            r_top <= '0;
                            r_bot <= h - 11'd1;
                            r_fin <= 1'b1;
                        end else begin
                            r_dlw <= 1'b1;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_column  = r_ocol;
    assign o_span_top    = r_otop;
    assign o_span_bottom = r_obot;
    assign o_hit_side    = r_oside;
    assign o_wall_found  = r_ofound;
endmodule

[hw/rtl/gdda_checker.sv]
module gdda_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_action,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [9:0]  o_out_column,
    input logic [9:0]  o_span_top,
    input logic [9:0]  o_span_bottom,
    input logic        o_wall_found
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_column)
            && $stable(o_span_top) && $stable(o_span_bottom))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_action |=> o_in_stall)
        else $error("cast beat did not make the block busy");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_wall_found |-> o_span_top == 10'd0 && o_span_bottom == 10'd0)
        else $error("miss with nonzero span");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block ready right after reset");
endmodule

bind grid_dda_ray_column_caster gdda_checker u_gdda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_action      (i_action),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_column  (o_out_column),
    .o_span_top    (o_span_top),
    .o_span_bottom (o_span_bottom),
    .o_wall_found  (o_wall_found)
);
